/* sv/fppc_pkg.sv */
// Shared types and constants for the first-packet protocol classifier.
// Holds the service and verdict codes, the signature bytes and the client-name table.
// No dependencies.
`default_nettype none

package fppc_pkg;

  // service codes (configuration register)
  localparam logic [2:0] SVC_NONE   = 3'd0;
  localparam logic [2:0] SVC_SSH    = 3'd1;
  localparam logic [2:0] SVC_HTTP   = 3'd2;
  localparam logic [2:0] SVC_HTTPS  = 3'd3;
  localparam logic [2:0] SVC_MSTSC  = 3'd4;
  localparam logic [2:0] SVC_RDP    = 3'd5;
  localparam logic [2:0] SVC_VNC    = 3'd6;
  localparam logic [2:0] SVC_TELNET = 3'd7;

  // verdict codes
  localparam logic [1:0] V_UNDECIDED = 2'd0;
  localparam logic [1:0] V_VERIFIED  = 2'd1;
  localparam logic [1:0] V_BLOCKED   = 2'd2;

  // fixed-position signature bytes
  localparam logic [7:0] SSH_HEAD [3] = '{8'h53, 8'h53, 8'h48};
  localparam logic [7:0] RDP_HEAD [3] = '{8'h03, 8'h00, 8'h00};
  localparam logic [7:0] VNC_HEAD [4] = '{8'h52, 8'h46, 8'h42, 8'h20};
  localparam logic [7:0] COOKIE_TXT [7] = '{8'h43, 8'h6F, 8'h6F, 8'h6B, 8'h69, 8'h65, 8'h3A};
  localparam logic [31:0] HTTP_WORDS [4] = '{32'h47455420, 32'h504F5354,
                                              32'h48454144, 32'h50555420};
  localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0] TLS_MAJOR     = 8'h03;
  localparam logic [7:0] X224_CR       = 8'hE0;
  localparam logic [7:0] RDP_NEG_REQ   = 8'h0B;
  localparam logic [7:0] TELNET_IAC    = 8'hFF;
  localparam logic [7:0] TELNET_WILL   = 8'hFB;

  // client-name table; rows padded with zeros past their length
  localparam int unsigned NAME_COUNT = 20;
  localparam int unsigned NAME_MAX   = 10;
  localparam int unsigned NAME_CELLS = NAME_MAX - 1;

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd7, 4'd5, 4'd6, 4'd9, 4'd9, 4'd6, 4'd7, 4'd10, 4'd9, 4'd5,
    4'd9, 4'd7, 4'd5, 4'd9, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd8
  };

  localparam logic [7:0] NAME_TXT [NAME_COUNT][NAME_MAX] = '{
    '{8'h4F, 8'h70, 8'h65, 8'h6E, 8'h53, 8'h53, 8'h48, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h75, 8'h54, 8'h54, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h69, 8'h6E, 8'h53, 8'h43, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h46, 8'h69, 8'h6C, 8'h65, 8'h5A, 8'h69, 8'h6C, 8'h6C, 8'h61, 8'h00},
    '{8'h53, 8'h65, 8'h63, 8'h75, 8'h72, 8'h65, 8'h43, 8'h52, 8'h54, 8'h00},
    '{8'h58, 8'h73, 8'h68, 8'h65, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h69, 8'h74, 8'h76, 8'h69, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h53, 8'h48, 8'h20, 8'h54, 8'h65, 8'h63, 8'h74, 8'h69, 8'h61},
    '{8'h54, 8'h65, 8'h72, 8'h61, 8'h20, 8'h54, 8'h65, 8'h72, 8'h6D, 8'h00},
    '{8'h4B, 8'h69, 8'h54, 8'h54, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h6F, 8'h79, 8'h61, 8'h6C, 8'h20, 8'h54, 8'h53, 8'h58, 8'h00},
    '{8'h54, 8'h65, 8'h72, 8'h6D, 8'h69, 8'h75, 8'h73, 8'h00, 8'h00, 8'h00},
    '{8'h54, 8'h61, 8'h62, 8'h62, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h43, 8'h79, 8'h62, 8'h65, 8'h72, 8'h64, 8'h75, 8'h63, 8'h6B, 8'h00},
    '{8'h46, 8'h6F, 8'h72, 8'h6B, 8'h4C, 8'h69, 8'h66, 8'h74, 8'h00, 8'h00},
    '{8'h54, 8'h72, 8'h61, 8'h6E, 8'h73, 8'h6D, 8'h69, 8'h74, 8'h00, 8'h00},
    '{8'h43, 8'h6F, 8'h72, 8'h65, 8'h46, 8'h54, 8'h50, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h6D, 8'h61, 8'h72, 8'h74, 8'h46, 8'h54, 8'h50, 8'h00, 8'h00},
    '{8'h46, 8'h6C, 8'h61, 8'h73, 8'h68, 8'h46, 8'h58, 8'h50, 8'h00, 8'h00},
    '{8'h46, 8'h54, 8'h50, 8'h20, 8'h52, 8'h75, 8'h73, 8'h68, 8'h00, 8'h00}
  };

  // shift control shared by the window cells
  typedef struct packed {
    logic shift;  // an item is accepted this cycle
    logic flush;  // new connection: window reads as empty before this byte
    logic drop;   // last byte: window empties after this byte
  } ctl_t;

  // one result item
  typedef struct packed {
    logic blocked;
    logic newly_decided;
  } res_t;

  // Per-name hit for one window slot: slot pos holds the byte pos places
  // back from the newest, which must equal the name's char counted from
  // its end. Slots past a name's length always hit.
  function automatic logic [NAME_COUNT-1:0] name_col_hit(input logic [3:0] pos,
                                                         input logic [7:0] b);
    logic [3:0]            idx;
    logic [NAME_COUNT-1:0] hit;
    hit = '0;
    idx = '0;
    for (int n = 0; n < NAME_COUNT; n++) begin
      if (pos >= NAME_LEN[n]) begin
        hit[n] = 1'b1;
      end else begin
        idx    = NAME_LEN[n] - pos - 4'd1;
        hit[n] = (b == NAME_TXT[n][idx]);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* sv/fppc_name_cell.sv */
// One cell of the client-name window: holds one past byte and matches it
// against its column of the name table. Depends on fppc_pkg.
`default_nettype none

module fppc_name_cell
  import fppc_pkg::*;
#(
  parameter int unsigned POS = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  ctl,
  input  wire logic [7:0]            byte_in,
  output logic      [7:0]            byte_out,
  output logic      [NAME_COUNT-1:0] hit
);

  logic [7:0] held;

  // shift in from the neighbor, empty after the last byte of a packet
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else if (ctl.shift) begin
      held <= ctl.drop ? 8'd0 : byte_in;
    end
  end

  // a new connection drops the partial packet
  assign byte_out = ctl.flush ? 8'd0 : held;

  assign hit = name_col_hit(4'(POS), byte_out);

endmodule

`default_nettype wire

/* sv/fppc_out_fifo.sv */
// Two-entry result queue between the classifier and the output channel.
// Depends on fppc_pkg.
`default_nettype none

module fppc_out_fifo
  import fppc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t din,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      dout
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  res_t       ent0;
  res_t       ent0_next;
  res_t       ent1;
  res_t       ent1_next;
  logic       pop;
  logic [1:0] slot;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (cnt != 2'd0);
  assign full      = (cnt == 2'd2);
  assign dout      = ent0;

  // pop shifts the tail forward; push lands in the first free slot
  always_comb begin
    ent0_next = ent0;
    ent1_next = ent1;
    slot      = cnt - {1'b0, pop};
    if (pop) begin
      ent0_next = ent1;
    end
    if (push) begin
      if (slot == 2'd0) begin
        ent0_next = din;
      end else begin
        ent1_next = din;
      end
    end
    cnt_next = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ent0 <= ent0_next;
    ent1 <= ent1_next;
  end

endmodule

`default_nettype wire

/* sv/first_packet_protocol_classifier_unit.sv */
// First-packet protocol classifier, top level.
// Uses fppc_pkg, fppc_name_cell and fppc_out_fifo.
//
// Input channel (in_valid / in_stall): one packet byte per item with
// new_connection and last_byte flags. An item is taken on every cycle
// where in_valid is high and in_stall low; one byte per cycle sustained
// while the result queue has room.
// Output channel (out_valid / out_stall): one item per packet, issued for
// its last byte, carrying blocked and newly_decided. The item is registered
// in the result queue when the last byte is taken, behind any earlier items.
// Middle bytes give no item. The client-name search runs in a row of
// window cells that shift one byte per accepted item, so the window keeps
// pace with the input at one byte per cycle.
// Results wait in a two-entry queue; input stalls only while both entries
// are full, i.e. when the receiver has held out_stall long enough.
// The service register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle (not enforced by the block).
// Reset (rst, synchronous): service none, verdict undecided, packet state
// and window cleared, result queue empty. No clearing pass is needed.
`default_nettype none

module first_packet_protocol_classifier_unit
  import fppc_pkg::*;
#(
  parameter int unsigned MAX_PACKET_LEN = 65535
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       new_connection,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            blocked,
  output logic            newly_decided
);

  localparam int unsigned PW = $clog2(MAX_PACKET_LEN + 1);

  logic [2:0]    svc_sel;
  logic [1:0]    verdict;
  logic [PW-1:0] byte_pos;
  logic          sig_ok;
  logic          name_found;
  logic          zero_seen;

  logic          in_acc;
  ctl_t          ctl;
  logic [PW-1:0] p_eff;
  logic [PW-1:0] count;
  logic [1:0]    verdict_eff;
  logic          sig_eff;
  logic          name_eff;
  logic          zero_eff;
  logic          fits;
  logic          pkt_match;
  logic          sig_next;
  logic          name_next;
  logic          zero_next;
  logic          name_hit;
  logic [31:0]   head_word;
  logic          http_ok;
  res_t          res;
  res_t          res_out;
  logic          fifo_full;

  logic [7:0]            win   [NAME_CELLS];
  logic [NAME_COUNT-1:0] c_hit [NAME_CELLS];
  logic [NAME_COUNT-1:0] all_hit;

  assign in_acc    = in_valid & ~in_stall;
  assign ctl.shift = in_acc;
  assign ctl.flush = new_connection;
  assign ctl.drop  = last_byte;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      svc_sel <= SVC_NONE;
    end else if (cfg_wr_en) begin
      svc_sel <= cfg_wr_data;
    end
  end

  // window cells, newest byte enters at cell 0
  for (genvar k = 0; k < NAME_CELLS; k++) begin : g_cell
    logic [7:0] chain_in;
    if (k == 0) begin : g_head
      assign chain_in = data_byte;
    end else begin : g_body
      assign chain_in = win[k-1];
    end
    fppc_name_cell #(
      .POS (k + 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .byte_in  (chain_in),
      .byte_out (win[k]),
      .hit      (c_hit[k])
    );
  end

  // a name ends at the current byte when every slot agrees
  always_comb begin
    all_hit = name_col_hit(4'd0, data_byte);
    for (int k = 0; k < NAME_CELLS; k++) begin
      all_hit = all_hit & c_hit[k];
    end
    name_hit = |all_hit;
  end

  // per-connection and per-packet state as seen by this byte
  assign p_eff       = new_connection ? '0 : byte_pos;
  assign verdict_eff = new_connection ? V_UNDECIDED : verdict;
  assign sig_eff     = new_connection ? 1'b1 : sig_ok;
  assign name_eff    = new_connection ? 1'b0 : name_found;
  assign zero_eff    = new_connection ? 1'b0 : zero_seen;
  assign count       = (p_eff < PW'(MAX_PACKET_LEN)) ? p_eff + PW'(1) : PW'(MAX_PACKET_LEN);

  // bytes 0..3 of the packet, oldest first, at position 3
  assign head_word = {win[2], win[1], win[0], data_byte};

  always_comb begin
    http_ok = 1'b0;
    for (int w = 0; w < 4; w++) begin
      http_ok = http_ok | (head_word == HTTP_WORDS[w]);
    end
  end

  // fixed-position check of this byte
  always_comb begin
    fits = 1'b1;
    unique case (svc_sel)
      SVC_SSH: begin
        if (p_eff < PW'(3)) fits = (data_byte == SSH_HEAD[p_eff[1:0]]);
      end
      SVC_HTTP: begin
        if (p_eff == PW'(3)) fits = http_ok;
      end
      SVC_HTTPS: begin
        if (p_eff == PW'(0)) fits = (data_byte == TLS_HANDSHAKE);
        else if (p_eff == PW'(1)) fits = (data_byte == TLS_MAJOR);
      end
      SVC_MSTSC: begin
        if (p_eff < PW'(3)) fits = (data_byte == RDP_HEAD[p_eff[1:0]]);
        else if (p_eff == PW'(5)) fits = (data_byte == X224_CR);
        else if (p_eff >= PW'(11) && p_eff <= PW'(17))
          fits = (data_byte == COOKIE_TXT[3'(p_eff - PW'(11))]);
        else if (p_eff == PW'(43)) fits = (data_byte == RDP_NEG_REQ);
      end
      SVC_RDP: begin
        if (p_eff < PW'(3)) fits = (data_byte == RDP_HEAD[p_eff[1:0]]);
      end
      SVC_VNC: begin
        if (p_eff < PW'(4)) fits = (data_byte == VNC_HEAD[p_eff[1:0]]);
      end
      SVC_TELNET: begin
        if (p_eff == PW'(0)) fits = (data_byte == TELNET_IAC);
        else if (p_eff == PW'(1)) fits = (data_byte == TELNET_WILL);
      end
      default: fits = 1'b1;
    endcase
  end

  assign sig_next  = sig_eff & fits;
  assign zero_next = zero_eff | (data_byte == 8'd0);
  assign name_next = name_eff | ((data_byte != 8'd0) & ~zero_eff & name_hit);

  // whole-packet decision on the last byte
  always_comb begin
    unique case (svc_sel)
      SVC_NONE:  pkt_match = 1'b1;
      SVC_SSH:   pkt_match = sig_next & (count >= PW'(20)) & name_next;
      SVC_HTTP:  pkt_match = sig_next & (count >= PW'(4));
      SVC_HTTPS: pkt_match = sig_next & (count >= PW'(3));
      SVC_MSTSC: pkt_match = sig_next & (count == PW'(47));
      SVC_RDP:   pkt_match = sig_next & (count >= PW'(19));
      SVC_VNC:   pkt_match = sig_next & (count >= PW'(4));
      default:   pkt_match = sig_next & (count >= PW'(3));
    endcase
  end

  always_comb begin
    res.newly_decided = (verdict_eff == V_UNDECIDED);
    if (verdict_eff == V_UNDECIDED) begin
      res.blocked = ~pkt_match;
    end else begin
      res.blocked = (verdict_eff == V_BLOCKED);
    end
  end

  // state update per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict    <= V_UNDECIDED;
      byte_pos   <= '0;
      sig_ok     <= 1'b1;
      name_found <= 1'b0;
      zero_seen  <= 1'b0;
    end else if (in_acc) begin
      if (last_byte) begin
        if (verdict_eff == V_UNDECIDED) begin
          verdict <= pkt_match ? V_VERIFIED : V_BLOCKED;
        end else begin
          verdict <= verdict_eff;
        end
        byte_pos   <= '0;
        sig_ok     <= 1'b1;
        name_found <= 1'b0;
        zero_seen  <= 1'b0;
      end else begin
        verdict    <= verdict_eff;
        byte_pos   <= count;
        sig_ok     <= sig_next;
        name_found <= name_next;
        zero_seen  <= zero_next;
      end
    end
  end

  // result queue
  fppc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc & last_byte),
    .din       (res),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign in_stall      = fifo_full;
  assign blocked       = res_out.blocked;
  assign newly_decided = res_out.newly_decided;

  // input only stalls behind queued results
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // a finished packet always leaves a settled verdict
  a_verdict_settled: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_byte) |=> (verdict != V_UNDECIDED))
    else $error("verdict still undecided after a packet");

  // packet state restarts after the last byte
  a_packet_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_byte) |=>
      (byte_pos == '0 && sig_ok && !name_found && !zero_seen))
    else $error("packet state not cleared after last byte");

  // a result is queued the cycle after every last byte
  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_byte) |=> out_valid)
    else $error("no result after last byte");

endmodule

`default_nettype wire

/* bench/fppc_verdict_checker.sv */
// Verdict checker for the first-packet protocol classifier.
// Watches the byte, result and configuration ports, predicts each packet's verdict
// and compares it with the result items. Depends on fppc_pkg.
`timescale 1ns / 1ps

module fppc_verdict_checker
  import fppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       new_connection,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       blocked,
  input  logic       newly_decided,
  output int         fail_count,
  output int         outstanding
);

  localparam int CLIENT_NAMES = 20;
  localparam int WINDOW       = 10;

  // signature bytes, first byte of the packet in the top bits
  localparam logic [23:0]  SIG_SSH    = 24'h535348;
  localparam logic [23:0]  SIG_RDP    = 24'h030000;
  localparam logic [31:0]  SIG_VNC    = 32'h52464220;
  localparam logic [55:0]  SIG_COOKIE = 56'h436F6F6B69653A;
  localparam logic [127:0] SIG_HTTP   = 128'h47455420_504F5354_48454144_50555420;
  localparam logic [7:0]   TLS_REC    = 8'h16;
  localparam logic [7:0]   TLS_VER    = 8'h03;
  localparam logic [7:0]   CONN_REQ   = 8'hE0;
  localparam logic [7:0]   NEG_TYPE   = 8'h0B;
  localparam logic [7:0]   IAC        = 8'hFF;
  localparam logic [7:0]   WILL       = 8'hFB;
  localparam logic [15:0]  POS_CAP    = 16'hFFFF;

  typedef struct packed {
    logic blocked;
    logic newly_decided;
  } packet_verdict_t;

  // predicted state of the block
  logic [2:0]      active_service;
  logic [1:0]      conn_verdict;
  logic [15:0]     pkt_pos;
  logic            head_ok;
  logic [7:0]      recent [WINDOW];
  logic            name_seen;
  logic            zero_seen;
  packet_verdict_t expected_verdicts [$];
  int              mismatches = 0;

  // client names, last character in the low byte, zero above the name
  function automatic logic [79:0] client_name(input int n);
    case (n)
      0:       return 80'h4F70656E535348;
      1:       return 80'h5075545459;
      2:       return 80'h57696E534350;
      3:       return 80'h46696C655A696C6C61;
      4:       return 80'h536563757265435254;
      5:       return 80'h587368656C6C;
      6:       return 80'h42697476697365;
      7:       return 80'h53534820546563746961;
      8:       return 80'h54657261205465726D;
      9:       return 80'h4B69545459;
      10:      return 80'h526F79616C20545358;
      11:      return 80'h5465726D697573;
      12:      return 80'h5461626279;
      13:      return 80'h43796265726475636B;
      14:      return 80'h466F726B4C696674;
      15:      return 80'h5472616E736D6974;
      16:      return 80'h436F7265465450;
      17:      return 80'h536D617274465450;
      18:      return 80'h466C617368465850;
      default: return 80'h4654502052757368;
    endcase
  endfunction

  // does any client name end at the newest byte
  function automatic logic name_at_end();
    logic [79:0] txt;
    logic        hit;
    for (int n = 0; n < CLIENT_NAMES; n++) begin
      txt = client_name(n);
      hit = 1'b1;
      for (int k = 0; k < WINDOW; k++) begin
        if (txt[8*k +: 8] != 8'h00 && recent[k] != txt[8*k +: 8]) hit = 1'b0;
      end
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  // window holds packet bytes 0..3 when called at position 3
  function automatic logic http_method_ok();
    for (int w = 0; w < 4; w++) begin
      if ({recent[3], recent[2], recent[1], recent[0]} == SIG_HTTP[32*(3-w) +: 32])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // fixed-position byte test for one service
  function automatic logic byte_fits(input logic [2:0] svc, input int q, input logic [7:0] b);
    case (svc)
      SVC_SSH: begin
        if (q < 3) return b == SIG_SSH[8*(2-q) +: 8];
      end
      SVC_HTTP: begin
        if (q == 3) return http_method_ok();
      end
      SVC_HTTPS: begin
        if (q == 0) return b == TLS_REC;
        if (q == 1) return b == TLS_VER;
      end
      SVC_MSTSC: begin
        if (q < 3) return b == SIG_RDP[8*(2-q) +: 8];
        if (q == 5) return b == CONN_REQ;
        if (q >= 11 && q <= 17) return b == SIG_COOKIE[8*(17-q) +: 8];
        if (q == 43) return b == NEG_TYPE;
      end
      SVC_RDP: begin
        if (q < 3) return b == SIG_RDP[8*(2-q) +: 8];
      end
      SVC_VNC: begin
        if (q < 4) return b == SIG_VNC[8*(3-q) +: 8];
      end
      SVC_TELNET: begin
        if (q == 0) return b == IAC;
        if (q == 1) return b == WILL;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // whole-packet decision for an undecided connection
  function automatic logic packet_ok(input logic [2:0] svc, input int cnt);
    case (svc)
      SVC_NONE:  return 1'b1;
      SVC_SSH:   return head_ok && cnt >= 20 && name_seen;
      SVC_HTTP:  return head_ok && cnt >= 4;
      SVC_HTTPS: return head_ok && cnt >= 3;
      SVC_MSTSC: return head_ok && cnt == 47;
      SVC_RDP:   return head_ok && cnt >= 19;
      SVC_VNC:   return head_ok && cnt >= 4;
      default:   return head_ok && cnt >= 3;
    endcase
  endfunction

  function automatic void clear_packet();
    pkt_pos   = '0;
    head_ok   = 1'b1;
    name_seen = 1'b0;
    zero_seen = 1'b0;
    for (int k = 0; k < WINDOW; k++) recent[k] = 8'h00;
  endfunction

  // advance the prediction by one accepted byte
  task automatic track_byte(input logic nc, input logic [7:0] b, input logic lst);
    int              q;
    logic [15:0]     cnt;
    logic            ok;
    packet_verdict_t v;
    if (nc) begin
      conn_verdict = V_UNDECIDED;
      clear_packet();
    end
    q       = pkt_pos;
    cnt     = (pkt_pos == POS_CAP) ? pkt_pos : pkt_pos + 16'd1;
    pkt_pos = cnt;
    for (int k = WINDOW - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = b;
    if (!byte_fits(active_service, q, b)) head_ok = 1'b0;
    // name search stops at the first zero byte
    if (b == 8'h00) zero_seen = 1'b1;
    else if (!zero_seen && name_at_end()) name_seen = 1'b1;
    if (lst) begin
      case (conn_verdict)
        V_VERIFIED: v = '{blocked: 1'b0, newly_decided: 1'b0};
        V_UNDECIDED: begin
          ok           = packet_ok(active_service, cnt);
          conn_verdict = ok ? V_VERIFIED : V_BLOCKED;
          v            = '{blocked: !ok, newly_decided: 1'b1};
        end
        default: v = '{blocked: 1'b1, newly_decided: 1'b0};
      endcase
      expected_verdicts.push_back(v);
      clear_packet();
    end
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("verdict check at %0t: %s", $time, msg);
  endtask

  task automatic check_result();
    packet_verdict_t v;
    if (expected_verdicts.size() == 0) begin
      flag($sformatf("result item with no packet pending (blocked %0b, newly_decided %0b)",
                     blocked, newly_decided));
    end else begin
      v = expected_verdicts.pop_front();
      if (blocked !== v.blocked)
        flag($sformatf("blocked expected %0b, got %0b", v.blocked, blocked));
      if (newly_decided !== v.newly_decided)
        flag($sformatf("newly_decided expected %0b, got %0b",
                       v.newly_decided, newly_decided));
    end
  endtask

  // byte first: its result cannot show before the next edge
  always @(posedge clk) begin
    if (rst) begin
      active_service = SVC_NONE;
      conn_verdict   = V_UNDECIDED;
      clear_packet();
      expected_verdicts.delete();
    end else begin
      if (in_valid && !in_stall) track_byte(new_connection, data_byte, last_byte);
      if (cfg_wr_en) active_service = cfg_wr_data;
      if (out_valid && !out_stall) check_result();
    end
    outstanding <= expected_verdicts.size();
    fail_count  <= mismatches;
  end

endmodule

/* bench/tb.sv */
// Testbench top for the first-packet protocol classifier.
// Sends packets byte by byte, changes the service between phases and gives the
// verdict; prediction and compare live in fppc_verdict_checker. Depends on fppc_pkg.
`timescale 1ns / 1ps

module tb;
  import fppc_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 450;
  localparam int MIN_PACKETS   = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = SVC_NONE;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       new_connection = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       blocked;
  logic       newly_decided;
  int         fail_count;
  int         outstanding;
  int         quiet_cycles = 0;
  int         items_sent = 0;
  int         packets_done = 0;
  bit         idle_en = 1'b0;
  logic [7:0] pkt [$];

  always #4 clk = ~clk;

  first_packet_protocol_classifier_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .new_connection (new_connection),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .blocked        (blocked),
    .newly_decided  (newly_decided)
  );

  fppc_verdict_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .new_connection (new_connection),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .blocked        (blocked),
    .newly_decided  (newly_decided),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // no progress on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("first_packet_protocol_classifier_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_filler(input int n, input bit no_zero);
    for (int k = 0; k < n; k++) pkt.push_back(no_zero ? text_byte() : any_byte());
  endtask

  // one item, with an optional sender gap ahead of it
  task automatic push_byte(input logic nc, input logic [7:0] b, input logic lst);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    new_connection <= nc;
    data_byte      <= b;
    last_byte      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_packet(input logic nc, input logic complete);
    for (int i = 0; i < pkt.size(); i++)
      push_byte(nc && i == 0, pkt[i], complete && i == pkt.size() - 1);
    if (complete) packets_done++;
  endtask

  // register write once all results are in and the block has settled
  task automatic set_service(input logic [2:0] svc);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= svc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic noise_packet();
    pkt.delete();
    add_filler($urandom_range(1, 24), 1'b0);
  endtask

  // packet that carries the service's signature, random elsewhere
  task automatic build_packet(input logic [2:0] svc);
    int n;
    int w;
    pkt.delete();
    case (svc)
      SVC_SSH: begin
        for (int k = 0; k < 3; k++) pkt.push_back(SSH_HEAD[k]);
        add_filler($urandom_range(0, 12), 1'b1);
        if ($urandom_range(0, 5) != 0) begin
          n = $urandom_range(0, NAME_COUNT - 1);
          for (int k = 0; k < NAME_LEN[n]; k++) pkt.push_back(NAME_TXT[n][k]);
        end
        add_filler($urandom_range(0, 10), 1'b1);
      end
      SVC_HTTP: begin
        w = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) pkt.push_back(HTTP_WORDS[w][8*(3-k) +: 8]);
        add_filler($urandom_range(0, 16), 1'b0);
      end
      SVC_HTTPS: begin
        pkt.push_back(TLS_HANDSHAKE);
        pkt.push_back(TLS_MAJOR);
        add_filler($urandom_range(1, 16), 1'b0);
      end
      SVC_MSTSC: begin
        add_filler(47, 1'b0);
        for (int k = 0; k < 3; k++) pkt[k] = RDP_HEAD[k];
        pkt[5] = X224_CR;
        for (int k = 0; k < 7; k++) pkt[11+k] = COOKIE_TXT[k];
        pkt[43] = RDP_NEG_REQ;
      end
      SVC_RDP: begin
        for (int k = 0; k < 3; k++) pkt.push_back(RDP_HEAD[k]);
        add_filler($urandom_range(14, 24), 1'b0);
      end
      SVC_VNC: begin
        for (int k = 0; k < 4; k++) pkt.push_back(VNC_HEAD[k]);
        add_filler($urandom_range(0, 16), 1'b0);
      end
      SVC_TELNET: begin
        pkt.push_back(TELNET_IAC);
        pkt.push_back(TELNET_WILL);
        add_filler($urandom_range(1, 16), 1'b0);
      end
      default: add_filler($urandom_range(1, 16), 1'b0);
    endcase
  endtask

  // break a byte, the length, or drop a zero into the packet
  task automatic damage_packet();
    int span;
    span = (pkt.size() < 48) ? pkt.size() : 48;
    case ($urandom_range(0, 3))
      0:       pkt[$urandom_range(0, span - 1)] = any_byte();
      1:       if (pkt.size() > 1) void'(pkt.pop_back());
      2:       pkt.push_back(any_byte());
      default: pkt[$urandom_range(0, pkt.size() - 1)] = 8'h00;
    endcase
  endtask

  initial begin
    int         ph;
    int         pick;
    logic       nc;
    logic [2:0] phase_svc;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // service none verifies anything, and the verdict then sticks
    set_service(SVC_NONE);
    pkt = '{8'h00};
    send_packet(1'b1, 1'b1);
    pkt = '{8'hFF};
    send_packet(1'b0, 1'b1);

    // telnet: good head, bad head, sticky block, too short, dropped partial
    set_service(SVC_TELNET);
    pkt = '{TELNET_IAC, TELNET_WILL, 8'h01};
    send_packet(1'b1, 1'b1);
    pkt = '{TELNET_IAC, 8'hFA, 8'h01};
    send_packet(1'b1, 1'b1);
    pkt = '{TELNET_IAC, TELNET_WILL, 8'h02};
    send_packet(1'b0, 1'b1);
    pkt = '{TELNET_IAC, TELNET_WILL};
    send_packet(1'b1, 1'b1);
    pkt = '{8'h00, 8'h01};
    send_packet(1'b1, 1'b0);
    pkt = '{TELNET_IAC, TELNET_WILL, 8'h80};
    send_packet(1'b1, 1'b1);

    // random phases: every service once in turn, then at random
    items_sent   = 0;
    packets_done = 0;
    for (ph = 0; items_sent < RANDOM_ITEMS || packets_done < MIN_PACKETS; ph++) begin
      phase_svc = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      set_service(phase_svc);
      idle_en = (items_sent < RANDOM_ITEMS - 80) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 5; k++) begin
        nc   = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        // abandoned partial packet, then a fresh connection
        if (pick == 0) begin
          noise_packet();
          send_packet(nc, 1'b0);
          nc = 1'b1;
        end
        if (pick <= 1) begin
          noise_packet();
        end else begin
          build_packet(phase_svc);
          if ($urandom_range(0, 2) == 0) damage_packet();
        end
        send_packet(nc, 1'b1);
      end
    end

    // drain and let any stray result show
    idle_en = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("first_packet_protocol_classifier_unit: match");
    end else begin
      $display("first_packet_protocol_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
